FILE: hdl/gccs_pkg.sv
package gccs_pkg;

  typedef enum logic [1:0] {
    KIND_SET = 2'd0,
    KIND_ONE = 2'd1,
    KIND_ALL = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MASK,
    S_RMAX,
    S_MAX,
    S_REXP,
    S_EXP,
    S_MUL,
    S_ACC,
    S_POUT,
    S_DIV,
    S_EMIT,
    S_HOLD
  } state_e;

  function automatic logic [30:0] exp_const(input logic [3:0] idx);
    logic [30:0] v;
    begin
      case (idx)
        4'd0: v = 31'd1069555701;
        4'd1: v = 31'd1065385899;
        4'd2: v = 31'd1057094900;
        4'd3: v = 31'd1040706262;
        4'd4: v = 31'd1008687097;
        4'd5: v = 31'd947573834;
        4'd6: v = 31'd836230973;
        4'd7: v = 31'd651257332;
        4'd8: v = 31'd395007542;
        4'd9: v = 31'd145315154;
        4'd10: v = 31'd19666267;
        4'd11: v = 31'd360200;
        4'd12: v = 31'd121;
        default: v = 31'd1073741824;
      endcase
      return v;
    end
  endfunction

endpackage

FILE: hdl/gccs_exp.sv
// Iterative exp(-d/256): one table multiply per cycle over the 13 bits of d.
module gccs_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] d_i,
  output logic        done_o,
  output logic [30:0] e_o
);
  logic [30:0] acc_q, acc_d;
  logic [16:0] d_q, d_d;
  logic [3:0]  b_q, b_d;
  logic        busy_q, busy_d;
  logic [61:0] prod;

  assign prod = acc_q * gccs_pkg::exp_const(b_q);
  assign e_o = acc_q;

  always_comb begin
    acc_d = acc_q;
    d_d = d_q;
    b_d = b_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      d_d = d_i;
      b_d = 4'd0;
      acc_d = 31'd1073741824;
      if (d_i[16:13] != 4'd0) begin
        acc_d = 31'd0;
      end
    end else if (busy_q) begin
      if (d_q[b_q]) begin
        acc_d = prod[60:30];
      end
      if (b_q == 4'd12) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        b_d = b_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    d_q <= d_d;
    b_q <= b_d;
  end
endmodule

FILE: hdl/gccs_div.sv
// Restoring divider, one quotient bit per cycle: q = (n << 16) / s, 17 bits.
module gccs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] num_i,
  input  logic [33:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);
  logic [34:0] rem_q, rem_d;
  logic [33:0] den_q, den_d;
  logic [46:0] num_q, num_d;
  logic [16:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [35:0] trial;

  assign trial = {rem_q, num_q[46]} - {2'b00, den_q};
  assign quo_o = (quo_q[16]) ? 16'hFFFF : quo_q[15:0];

  always_comb begin
    rem_d = rem_q;
    den_d = den_q;
    num_d = num_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d = '0;
      den_d = den_i;
      num_d = {num_i, 16'd0};
      quo_d = '0;
      cnt_d = 6'd0;
    end else if (busy_q) begin
      num_d = {num_q[45:0], 1'b0};
      if (!trial[35]) begin
        rem_d = trial[34:0];
      end else begin
        rem_d = {rem_q[33:0], num_q[46]};
      end
      quo_d = {quo_q[15:0], !trial[35]};
      if (cnt_q == 6'd46) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q + 6'd1;
    end else if (cnt_q == 6'd47) begin
      done_o = 1'b1;
      cnt_d = 6'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 6'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end
endmodule

FILE: hdl/grid_cell_class_softmax.sv
// Channel | Direction | Signals
// in      | input     | in_valid_i, in_ready_o, kind_i, row_i, col_i, class_index_i,
//         |           | score_value_i
// out     | output    | out_valid_o, out_ready_i, result_class_o, probability_o,
//         |           | status_o, last_o
// One word is handled at a time. An out-of-range word is answered in the cycle after it is
// taken and a set after it passes through S_MASK. A query first finds the maximum over the
// present classes and then the sum through the shared exp unit; query one then uses the
// serial divider, and query all evaluates each exp again before dividing for each result.
// After reset a clearing pass zeroes all GRID_ROWS*GRID_COLS mask entries while in_ready_o
// is low. A stalled output blocks new words and the next result until the word is taken.
module grid_cell_class_softmax #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64,
  parameter int NUM_CLASSES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic signed [5:0] row_i,
  input  logic signed [5:0] col_i,
  input  logic [2:0]  class_index_i,
  input  logic signed [15:0] score_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_class_o,
  output logic [15:0] probability_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  localparam int NCELLS = GRID_ROWS * GRID_COLS;
  localparam int CW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int KN = (NUM_CLASSES < 8) ? NUM_CLASSES : 8;
  localparam int MINR = -(GRID_ROWS / 2);
  localparam int MINC = -(GRID_COLS / 2);

  logic [7:0]  mask_mem  [NCELLS];
  logic [15:0] score_mem [NCELLS*8];

  gccs_pkg::state_e st_q, st_d;
  logic [CW:0]  clr_q, clr_d;
  logic [CW-1:0] cell_q, cell_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  cls_q, cls_d;
  logic [2:0]  k_q, k_d;
  logic [7:0]  mask_q, mask_d;
  logic signed [15:0] max_q, max_d;
  logic [33:0] sum_q, sum_d;
  logic [30:0] ec_q, ec_d;
  logic        pass_q, pass_d;
  logic        ov_q, ov_d;
  logic [2:0]  oc_q, oc_d;
  logic [15:0] op_q, op_d;
  logic [1:0]  os_q, os_d;
  logic        ol_q, ol_d;

  logic        mwe, swe;
  logic [CW-1:0] maddr;
  logic [7:0]  mwdata, mrd_q;
  logic [CW+2:0] saddr;
  logic [15:0] srd_q;

  logic        ex_start, ex_done, dv_start, dv_done;
  logic [16:0] ex_d;
  logic [30:0] ex_e;
  logic [15:0] dv_q;

  logic signed [11:0] rs, cs;
  logic        in_ok, cls_ok;
  logic [CW-1:0] cell_in;
  logic [16:0] diff;
  logic [7:0]  hi_mask;

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mask_mem[maddr] <= mwdata;
    end
    mrd_q <= mask_mem[maddr];
  end

  always_ff @(posedge clk_i) begin
    if (swe) begin
      score_mem[saddr] <= score_value_i;
    end
    srd_q <= score_mem[saddr];
  end

  gccs_exp u_exp (
    .clk_i, .rst_ni, .start_i(ex_start), .d_i(ex_d), .done_o(ex_done), .e_o(ex_e)
  );

  gccs_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(ec_q), .den_i(sum_q),
    .done_o(dv_done), .quo_o(dv_q)
  );

  assign rs = 12'(row_i) - 12'(MINR);
  assign cs = 12'(col_i) - 12'(MINC);
  assign in_ok = (rs >= 0) && (rs < GRID_ROWS) && (cs >= 0) && (cs < GRID_COLS);
  assign cls_ok = 32'(class_index_i) < NUM_CLASSES;
  assign cell_in = CW'(32'(rs) * GRID_COLS + 32'(cs));
  assign diff = 17'($signed({max_q[15], max_q}) - $signed({srd_q[15], srd_q}));

  always_comb begin
    hi_mask = '0;
    for (int i = 0; i < 8; i++) begin
      hi_mask[i] = (i > int'(k_q));
    end
  end

  assign result_class_o = oc_q;
  assign probability_o = op_q;
  assign status_o = os_q;
  assign last_o = ol_q;
  assign out_valid_o = ov_q;

  always_comb begin
    st_d = st_q;
    clr_d = clr_q;
    cell_d = cell_q;
    kind_d = kind_q;
    cls_d = cls_q;
    k_d = k_q;
    mask_d = mask_q;
    max_d = max_q;
    sum_d = sum_q;
    ec_d = ec_q;
    pass_d = pass_q;
    ov_d = ov_q;
    oc_d = oc_q;
    op_d = op_q;
    os_d = os_q;
    ol_d = ol_q;
    mwe = 1'b0;
    swe = 1'b0;
    maddr = cell_q;
    mwdata = '0;
    saddr = {cell_q, k_q};
    ex_start = 1'b0;
    ex_d = diff;
    dv_start = 1'b0;
    in_ready_o = 1'b0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (st_q)
      gccs_pkg::S_IDLE: begin
        if (!clr_q[CW]) begin
          mwe = 1'b1;
          maddr = clr_q[CW-1:0];
          clr_d = clr_q + 1'b1;
          if (32'(clr_q) == NCELLS - 1) begin
            clr_d = {1'b1, {CW{1'b0}}};
          end
        end else if (!ov_q) begin
          in_ready_o = 1'b1;
          if (in_valid_i && kind_i != gccs_pkg::KIND_NONE) begin
            kind_d = kind_i;
            cls_d = class_index_i;
            cell_d = cell_in;
            maddr = cell_in;
            if (!in_ok) begin
              ov_d = 1'b1;
              oc_d = (kind_i == gccs_pkg::KIND_ALL) ? 3'd0 : class_index_i;
              op_d = '0;
              os_d = gccs_pkg::ST_RANGE;
              ol_d = 1'b1;
            end else if (kind_i == gccs_pkg::KIND_SET) begin
              if (cls_ok) begin
                swe = 1'b1;
                saddr = {cell_in, class_index_i};
              end
              st_d = gccs_pkg::S_MASK;
            end else begin
              st_d = gccs_pkg::S_MASK;
            end
          end
        end
      end
      gccs_pkg::S_MASK: begin
        mask_d = mrd_q & 8'((9'd1 << KN) - 9'd1);
        if (kind_q == gccs_pkg::KIND_SET) begin
          if (32'(cls_q) < NUM_CLASSES) begin
            mwe = 1'b1;
            mwdata = mrd_q | (8'd1 << cls_q);
          end
          ov_d = 1'b1;
          oc_d = cls_q;
          op_d = '0;
          os_d = gccs_pkg::ST_OK;
          ol_d = 1'b1;
          st_d = gccs_pkg::S_IDLE;
        end else if (mask_d == 8'd0) begin
          ov_d = 1'b1;
          oc_d = (kind_q == gccs_pkg::KIND_ONE) ? cls_q : 3'd0;
          op_d = '0;
          os_d = gccs_pkg::ST_EMPTY;
          ol_d = 1'b1;
          st_d = gccs_pkg::S_IDLE;
        end else begin
          k_d = '0;
          max_d = 16'sh8000;
          pass_d = 1'b0;
          st_d = gccs_pkg::S_RMAX;
        end
      end
      gccs_pkg::S_RMAX: begin
        st_d = gccs_pkg::S_MAX;
      end
      gccs_pkg::S_MAX: begin
        if (mask_q[k_q] && ($signed(srd_q) > max_q || !pass_q)) begin
          max_d = srd_q;
          pass_d = 1'b1;
        end
        if (k_q == 3'd7) begin
          k_d = '0;
          sum_d = '0;
          st_d = gccs_pkg::S_REXP;
        end else begin
          k_d = k_q + 3'd1;
          st_d = gccs_pkg::S_RMAX;
        end
      end
      gccs_pkg::S_REXP: begin
        if (!mask_q[k_q]) begin
          if (k_q == 3'd7) begin
            k_d = '0;
            st_d = gccs_pkg::S_POUT;
          end else begin
            k_d = k_q + 3'd1;
          end
        end else begin
          st_d = gccs_pkg::S_EXP;
        end
      end
      gccs_pkg::S_EXP: begin
        ex_start = 1'b1;
        st_d = gccs_pkg::S_MUL;
      end
      gccs_pkg::S_MUL: begin
        if (ex_done) begin
          st_d = gccs_pkg::S_ACC;
        end
      end
      gccs_pkg::S_ACC: begin
        if (pass_q) begin
          sum_d = sum_q + 34'(ex_e);
        end
        if (kind_q == gccs_pkg::KIND_ONE ? (k_q == cls_q) : 1'b0) begin
          ec_d = ex_e;
        end
        if (pass_q == 1'b0) begin
          ec_d = ex_e;
          st_d = gccs_pkg::S_DIV;
        end else if (k_q == 3'd7) begin
          k_d = '0;
          st_d = gccs_pkg::S_POUT;
        end else begin
          k_d = k_q + 3'd1;
          st_d = gccs_pkg::S_REXP;
        end
      end
      gccs_pkg::S_POUT: begin
        pass_d = 1'b0;
        if (kind_q == gccs_pkg::KIND_ONE) begin
          if (32'(cls_q) < NUM_CLASSES && mask_q[cls_q]) begin
            dv_start = 1'b1;
            st_d = gccs_pkg::S_EMIT;
          end else begin
            ov_d = 1'b1;
            oc_d = cls_q;
            op_d = '0;
            os_d = gccs_pkg::ST_OK;
            ol_d = 1'b1;
            st_d = gccs_pkg::S_IDLE;
          end
        end else if (!mask_q[k_q]) begin
          k_d = k_q + 3'd1;
        end else begin
          st_d = gccs_pkg::S_EXP;
        end
      end
      gccs_pkg::S_DIV: begin
        dv_start = 1'b1;
        st_d = gccs_pkg::S_EMIT;
      end
      gccs_pkg::S_EMIT: begin
        if (dv_done) begin
          st_d = gccs_pkg::S_HOLD;
        end
      end
      gccs_pkg::S_HOLD: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          op_d = dv_q;
          os_d = gccs_pkg::ST_OK;
          if (kind_q == gccs_pkg::KIND_ONE) begin
            oc_d = cls_q;
            ol_d = 1'b1;
            st_d = gccs_pkg::S_IDLE;
          end else begin
            oc_d = k_q;
            ol_d = ((mask_q & hi_mask) == 8'd0);
            if ((mask_q & hi_mask) == 8'd0) begin
              st_d = gccs_pkg::S_IDLE;
            end else begin
              k_d = k_q + 3'd1;
              pass_d = 1'b0;
              st_d = gccs_pkg::S_POUT;
            end
          end
        end
      end
      default: st_d = gccs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= gccs_pkg::S_IDLE;
      clr_q <= '0;
      ov_q <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      ov_q <= ov_d;
      pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    kind_q <= kind_d;
    cls_q <= cls_d;
    k_q <= k_d;
    mask_q <= mask_d;
    max_q <= max_d;
    sum_q <= sum_d;
    ec_q <= ec_d;
    oc_q <= oc_d;
    op_q <= op_d;
    os_q <= os_d;
    ol_q <= ol_d;
  end
endmodule

FILE: test/grid_cell_class_softmax_tb.sv
`timescale 1ns / 1ps

module grid_cell_class_softmax_tb;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam int CLASSES = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_WORDS = 180;
  localparam int QUIET_TAIL = 30;

  typedef struct {
    gccs_pkg::kind_e kind;
    logic signed [5:0] row;
    logic signed [5:0] col;
    logic [2:0] cls;
    logic signed [15:0] score;
    bit drain;
    bit quiet;
  } cell_word_t;

  typedef struct {
    logic [2:0] cls;
    logic [15:0] prob;
    gccs_pkg::status_e status;
    logic last;
  } prob_word_t;

  localparam longint FRAC_TAB[8] = '{1069555701, 1065385899, 1057094900, 1040706262,
                                     1008687097, 947573834, 836230973, 651257332};
  localparam longint WHOLE_TAB[5] = '{395007542, 145315154, 19666267, 360200, 121};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = gccs_pkg::KIND_SET;
  logic signed [5:0] row_i = '0;
  logic signed [5:0] col_i = '0;
  logic [2:0] class_index_i = '0;
  logic signed [15:0] score_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] result_class_o;
  logic [15:0] probability_o;
  logic [1:0] status_o;
  logic last_o;

  cell_word_t pending_q[$];
  prob_word_t expected_q[$];
  cell_word_t cur_word;
  logic signed [15:0] score_mem[int];
  logic [7:0] mask_mem[ROWS*COLS];
  int mismatches = 0;
  int cycles = 0;
  int send_gap = 0;
  int take_gap = 0;
  bit quiet_now = 1'b0;

  grid_cell_class_softmax DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .kind_i(kind_i), .row_i(row_i), .col_i(col_i),
    .class_index_i(class_index_i), .score_value_i(score_value_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .result_class_o(result_class_o), .probability_o(probability_o),
    .status_o(status_o), .last_o(last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint neg_exp(int unsigned d);
    int unsigned n;
    longint acc;
    n = d >> 8;
    acc = 64'd1 << 30;
    if (n >= 32) return 0;
    for (int b = 0; b < 8; b++) if (d[b]) acc = (acc * FRAC_TAB[b]) >> 30;
    for (int b = 0; b < 5; b++) if (n[b]) acc = (acc * WHOLE_TAB[b]) >> 30;
    return acc;
  endfunction

  function automatic logic [15:0] share_of(longint e, longint total);
    longint p;
    if (total == 0) return 16'd0;
    p = (e << 16) / total;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic prob_word_t mk(logic [2:0] c, logic [15:0] p, gccs_pkg::status_e s,
                                    logic l);
    prob_word_t w;
    w.cls = c; w.prob = p; w.status = s; w.last = l;
    return w;
  endfunction

  task automatic predict_word(cell_word_t w);
    int r, c, cell_idx, top, cnt, n;
    longint total;
    logic [7:0] mask;
    r = int'(w.row) + ROWS / 2;
    c = int'(w.col) + COLS / 2;
    if (w.kind == gccs_pkg::KIND_NONE) return;
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) begin
      expected_q.push_back(mk(w.kind == gccs_pkg::KIND_ALL ? 3'd0 : w.cls, 16'd0,
                              gccs_pkg::ST_RANGE, 1'b1));
      return;
    end
    cell_idx = r * COLS + c;
    if (w.kind == gccs_pkg::KIND_SET) begin
      if (w.cls < CLASSES) begin
        score_mem[cell_idx * CLASSES + w.cls] = w.score;
        mask_mem[cell_idx][w.cls] = 1'b1;
      end
      expected_q.push_back(mk(w.cls, 16'd0, gccs_pkg::ST_OK, 1'b1));
      return;
    end
    mask = mask_mem[cell_idx];
    if (mask == 0) begin
      expected_q.push_back(mk(w.kind == gccs_pkg::KIND_ONE ? w.cls : 3'd0, 16'd0,
                              gccs_pkg::ST_EMPTY, 1'b1));
      return;
    end
    top = -100000;
    total = 0;
    cnt = 0;
    for (int k = 0; k < CLASSES; k++)
      if (mask[k]) begin
        cnt++;
        if (int'(score_mem[cell_idx * CLASSES + k]) > top)
          top = score_mem[cell_idx * CLASSES + k];
      end
    for (int k = 0; k < CLASSES; k++)
      if (mask[k]) total += neg_exp(top - int'(score_mem[cell_idx * CLASSES + k]));
    if (w.kind == gccs_pkg::KIND_ONE) begin
      expected_q.push_back(mk(w.cls, mask[w.cls] ?
        share_of(neg_exp(top - int'(score_mem[cell_idx * CLASSES + w.cls])), total) : 16'd0,
        gccs_pkg::ST_OK, 1'b1));
      return;
    end
    n = 0;
    for (int k = 0; k < CLASSES; k++)
      if (mask[k]) begin
        n++;
        expected_q.push_back(mk(k[2:0],
          share_of(neg_exp(top - int'(score_mem[cell_idx * CLASSES + k])), total),
          gccs_pkg::ST_OK, n == cnt));
      end
  endtask

  function automatic cell_word_t word_of(gccs_pkg::kind_e k, int r, int c, int cl, int s);
    cell_word_t w;
    w.kind = k; w.row = 6'(r); w.col = 6'(c); w.cls = 3'(cl); w.score = 16'(s);
    w.drain = 1'b0; w.quiet = 1'b0;
    return w;
  endfunction

  always @(posedge clk_i) begin
    bit take;
    bit next_valid;
    cell_word_t nxt;
    take = 1'b0;
    next_valid = in_valid_i;
    nxt = cur_word;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_word(cur_word);
        next_valid = 1'b0;
        if (!quiet_now && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 12);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].drain) begin
            if (expected_q.size() == 0 && !in_valid_i) void'(pending_q.pop_front());
          end else begin
            nxt = pending_q.pop_front();
            quiet_now = nxt.quiet;
            next_valid = 1'b1;
            take = 1'b1;
          end
        end
      end
    end
    in_valid_i <= next_valid;
    if (take) begin
      cur_word <= nxt;
      kind_i <= nxt.kind;
      row_i <= nxt.row;
      col_i <= nxt.col;
      class_index_i <= nxt.cls;
      score_value_i <= nxt.score;
    end
  end

  always @(posedge clk_i) begin
    prob_word_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected word: class %0d prob %0d status %0d last %0d",
                                         result_class_o, probability_o, status_o, last_o);
        end else begin
          e = expected_q.pop_front();
          if (e.cls !== result_class_o || e.prob !== probability_o ||
              e.status !== status_o || e.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected class %0d prob %0d status %0d last %0d, got %0d %0d %0d %0d",
                       e.cls, e.prob, e.status, e.last,
                       result_class_o, probability_o, status_o, last_o);
          end
        end
        if (!quiet_now && $urandom_range(0, 3) == 0) take_gap = $urandom_range(1, 12);
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int hot_r[6];
    int hot_c[6];
    int h, roll, sc;
    cell_word_t w;
    foreach (mask_mem[i]) mask_mem[i] = '0;
    hot_r = '{-32, 31, 0, -1, 17, -9};
    hot_c = '{31, -32, 0, -1, -20, 5};

    pending_q.push_back(word_of(gccs_pkg::KIND_SET, 0, 0, 0, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_ONE, 0, 0, 0, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_ALL, 0, 0, 0, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_ONE, 5, 5, 4, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_ALL, 5, 5, 6, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_SET, -32, 31, 7, -32768));
    pending_q.push_back(word_of(gccs_pkg::KIND_SET, -32, 31, 0, 32767));
    pending_q.push_back(word_of(gccs_pkg::KIND_ALL, -32, 31, 0, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_ONE, -32, 31, 3, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_ONE, -32, 31, 7, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_NONE, 12, -12, 2, 100));
    for (int k = 0; k < 8; k++)
      pending_q.push_back(word_of(gccs_pkg::KIND_SET, 31, -32, k, k * 37 - 130));
    pending_q.push_back(word_of(gccs_pkg::KIND_ALL, 31, -32, 0, 0));
    pending_q.push_back(word_of(gccs_pkg::KIND_ONE, 31, -32, 5, 0));
    w.drain = 1'b1;
    pending_q.push_back(w);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        w.drain = 1'b1;
        pending_q.push_back(w);
      end
      h = $urandom_range(0, 5);
      if ($urandom_range(0, 4) == 0)
        w = word_of(gccs_pkg::KIND_SET, $urandom_range(0, 63) - 32,
                    $urandom_range(0, 63) - 32, 0, 0);
      else
        w = word_of(gccs_pkg::KIND_SET, hot_r[h], hot_c[h], 0, 0);
      w.cls = 3'($urandom_range(0, 7));
      sc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                        : $urandom_range(0, 4095) - 2048;
      w.score = 16'(sc);
      roll = $urandom_range(0, 99);
      if (roll < 45) w.kind = gccs_pkg::KIND_SET;
      else if (roll < 70) w.kind = gccs_pkg::KIND_ONE;
      else if (roll < 95) w.kind = gccs_pkg::KIND_ALL;
      else w.kind = gccs_pkg::KIND_NONE;
      w.quiet = (i >= RANDOM_WORDS - QUIET_TAIL);
      pending_q.push_back(w);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (800) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
